// ----- design/lkc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkc_pkg: shared types and codes for the LRU key-value cache
// Request codes and the classified request record passed front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lkc_pkg;

  localparam logic [1:0] REQ_SET     = 2'd0;
  localparam logic [1:0] REQ_SET_TTL = 2'd1;
  localparam logic [1:0] REQ_GET     = 2'd2;
  localparam logic [1:0] REQ_DEL     = 2'd3;

  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] CNT_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        is_set;
    logic        has_ttl;
    logic        is_get;
    logic        is_del;
    logic [63:0] key;
    logic [63:0] value;
    logic [47:0] expire;
    logic [47:0] now;
  } item_t;

endpackage

// ----- design/lkc_front.sv -----
// ----------------------------------------------------------------------------
// lkc_front: request intake and queue
// Decodes each request, computes its expiry time and queues it for the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lkc_front import lkc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_key,
  input  logic [63:0] in_value,
  input  logic [31:0] in_ttl,
  input  logic [47:0] in_now,
  output logic        busy,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t       q_mem_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  item_t       cls;
  logic [48:0] sum;
  logic        push;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_mem_r[rp_r];

  always_comb begin
    sum         = {1'b0, in_now} + {17'd0, in_ttl};
    cls.is_set  = (in_req_type == REQ_SET) || (in_req_type == REQ_SET_TTL);
    cls.has_ttl = (in_req_type == REQ_SET_TTL);
    cls.is_get  = (in_req_type == REQ_GET);
    cls.is_del  = (in_req_type == REQ_DEL);
    cls.key     = in_key;
    cls.value   = in_value;
    cls.now     = in_now;
    // The expiry saturates at the largest time value.
    if (!cls.has_ttl) begin
      cls.expire = '0;
    end else if (sum[48]) begin
      cls.expire = TIME_MAX;
    end else begin
      cls.expire = sum[47:0];
    end
  end

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- design/lkc_back.sv -----
// ----------------------------------------------------------------------------
// lkc_back: slot store and request execution
// A match cycle compares all slots, then an update cycle writes slots,
// recency ranks and statistics and registers the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lkc_back import lkc_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [4:0]  cap,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_strobe,
  output logic        out_found,
  output logic [63:0] out_read_value,
  output logic        out_evicted,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_miss_count,
  output logic [31:0] out_eviction_count,
  output logic [4:0]  out_entry_count
);

  localparam int RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CAPW = (CW > 5) ? CW + 1 : 6;
  localparam logic PH_MATCH  = 1'b0;
  localparam logic PH_UPDATE = 1'b1;

  logic [ENTRIES-1:0]    valid_r;
  logic [KEY_BITS-1:0]   key_r    [ENTRIES];
  logic [VALUE_BITS-1:0] value_r  [ENTRIES];
  logic                  hasexp_r [ENTRIES];
  logic [47:0]           exp_r    [ENTRIES];
  logic [RW-1:0]         rank_r   [ENTRIES];

  logic          phase_r, phase_nxt;
  logic [CW-1:0] live_r, live_nxt;
  logic [31:0]   hits_r, hits_nxt, miss_r, miss_nxt, evc_r, evc_nxt;

  // Match results, registered for the update cycle.
  item_t         item_r;
  logic          hit_r, hexp_r, full_r, free_ok_r;
  logic [RW-1:0] hidx_r, hrank_r, vidx_r, vrank_r, fidx_r;

  logic               m_hit, m_hexp, m_free_ok, m_full;
  logic [RW-1:0]      m_hidx, m_hrank, m_vidx, m_vrank, m_fidx;
  logic [ENTRIES-1:0] exp_by_rank;
  logic [CW-1:0]      live_m1;
  logic [CAPW-1:0]    eff_cap;

  logic          set_hit, ins, get_ok, rem, mru;
  logic [RW-1:0] ins_idx;

  logic              o_strobe_r, o_found_r, o_evicted_r;
  logic [63:0]       o_rd_r;

  assign q_pop   = (phase_r == PH_MATCH) && q_valid;
  assign live_m1 = live_r - CW'(1);

  always_comb begin
    if ((cap == 5'd0) || (CAPW'(cap) > CAPW'(ENTRIES))) begin
      eff_cap = CAPW'(ENTRIES);
    end else begin
      eff_cap = CAPW'(cap);
    end
    m_full = CAPW'(live_r) >= eff_cap;
  end

  // Match: key compare, expiry compare, victim and free slot search.
  always_comb begin
    m_hit       = 1'b0;
    m_hidx      = '0;
    m_hrank     = '0;
    m_hexp      = 1'b0;
    m_free_ok   = 1'b0;
    m_fidx      = '0;
    exp_by_rank = '0;
    m_vrank     = live_m1[RW-1:0];
    m_vidx      = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (valid_r[j] && (key_r[j] == q_item.key[KEY_BITS-1:0])) begin
        m_hit   = 1'b1;
        m_hidx  = RW'(j);
        m_hrank = rank_r[j];
        m_hexp  = hasexp_r[j] && (q_item.now >= exp_r[j]);
      end
      if (valid_r[j] && hasexp_r[j] && (q_item.now >= exp_r[j])) begin
        exp_by_rank[rank_r[j]] = 1'b1;
      end
    end
    for (int k = 0; k < ENTRIES; k++) begin
      if (exp_by_rank[k]) begin
        m_vrank = RW'(k);
      end
    end
    for (int j = 0; j < ENTRIES; j++) begin
      if (valid_r[j] && (rank_r[j] == m_vrank)) begin
        m_vidx = RW'(j);
      end
    end
    for (int j = ENTRIES - 1; j >= 0; j--) begin
      if (!valid_r[j]) begin
        m_free_ok = 1'b1;
        m_fidx    = RW'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r    <= q_item;
      hit_r     <= m_hit;
      hidx_r    <= m_hidx;
      hrank_r   <= m_hrank;
      hexp_r    <= m_hexp;
      vidx_r    <= m_vidx;
      vrank_r   <= m_vrank;
      fidx_r    <= m_fidx;
      free_ok_r <= m_free_ok;
      full_r    <= m_full;
    end
  end

  // Update: decide what the request does to the store.
  always_comb begin
    set_hit  = item_r.is_set && hit_r;
    ins      = item_r.is_set && !hit_r;
    get_ok   = item_r.is_get && hit_r && !hexp_r;
    rem      = (item_r.is_get && hit_r && hexp_r) || (item_r.is_del && hit_r);
    mru      = set_hit || get_ok;
    // When full, the insert takes the victim slot if it is lower than the first free one, or if none is free.
    if (full_r && (!free_ok_r || (vidx_r < fidx_r))) begin
      ins_idx = vidx_r;
    end else begin
      ins_idx = fidx_r;
    end
    phase_nxt = phase_r;
    live_nxt  = live_r;
    hits_nxt  = hits_r;
    miss_nxt  = miss_r;
    evc_nxt   = evc_r;
    if (phase_r == PH_MATCH) begin
      if (q_valid) begin
        phase_nxt = PH_UPDATE;
      end
    end else begin
      phase_nxt = PH_MATCH;
      if (ins) begin
        live_nxt = full_r ? live_r : live_r + CW'(1);
        if (full_r && (evc_r != CNT_MAX)) begin
          evc_nxt = evc_r + 32'd1;
        end
      end
      if (rem) begin
        live_nxt = live_m1;
      end
      if (get_ok && (hits_r != CNT_MAX)) begin
        hits_nxt = hits_r + 32'd1;
      end
      if (item_r.is_get && !get_ok && (miss_r != CNT_MAX)) begin
        miss_nxt = miss_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == PH_UPDATE) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (mru) begin
          if (RW'(j) == hidx_r) begin
            rank_r[j] <= '0;
          end else if (valid_r[j] && (rank_r[j] < hrank_r)) begin
            rank_r[j] <= rank_r[j] + RW'(1);
          end
        end
        if (rem && valid_r[j] && (rank_r[j] > hrank_r)) begin
          rank_r[j] <= rank_r[j] - RW'(1);
        end
        if (ins) begin
          if (RW'(j) == ins_idx) begin
            rank_r[j] <= '0;
            key_r[j]  <= item_r.key[KEY_BITS-1:0];
          end else if (valid_r[j] && !(full_r && (RW'(j) == vidx_r))) begin
            rank_r[j] <= rank_r[j] + RW'(1)
                         - RW'(full_r && (rank_r[j] > vrank_r));
          end
        end
        if ((ins && (RW'(j) == ins_idx)) || (set_hit && (RW'(j) == hidx_r))) begin
          value_r[j]  <= item_r.value[VALUE_BITS-1:0];
          hasexp_r[j] <= item_r.has_ttl;
          exp_r[j]    <= item_r.expire;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (phase_r == PH_UPDATE) begin
      if (rem) begin
        valid_r[hidx_r] <= 1'b0;
      end
      if (ins) begin
        if (full_r) begin
          valid_r[vidx_r] <= 1'b0;
        end
        valid_r[ins_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_MATCH;
      live_r     <= '0;
      hits_r     <= '0;
      miss_r     <= '0;
      evc_r      <= '0;
      o_strobe_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      live_r     <= live_nxt;
      hits_r     <= hits_nxt;
      miss_r     <= miss_nxt;
      evc_r      <= evc_nxt;
      o_strobe_r <= (phase_r == PH_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == PH_UPDATE) begin
      o_found_r   <= get_ok;
      o_rd_r      <= get_ok ? 64'(value_r[hidx_r]) : 64'd0;
      o_evicted_r <= ins && full_r;
    end
  end

  assign out_strobe         = o_strobe_r;
  assign out_found          = o_found_r;
  assign out_read_value     = o_rd_r;
  assign out_evicted        = o_evicted_r;
  assign out_hit_count      = hits_r;
  assign out_miss_count     = miss_r;
  assign out_eviction_count = evc_r;
  assign out_entry_count    = 5'(live_r);

endmodule

// ----- design/lru_kv_cache_with_expiry.sv -----
// ----------------------------------------------------------------------------
// lru_kv_cache_with_expiry: LRU key-value cache with per-entry expiry
// Front queues decoded requests; back matches and updates the slot store.
// ----------------------------------------------------------------------------
// With the queue empty, a start beat passes the queue, the match phase and the
// update phase of the back; out_strobe is registered from the update phase.
// The back takes a new request only once the last one is updated: its match
// and update phases share slot registers. Two requests queue before busy rises.
// Reset (synchronous, rst_n low) empties the store, queue and statistics.
// Results are issued as single-cycle strobed beats; the receiver cannot stall.
`timescale 1ns / 1ps
module lru_kv_cache_with_expiry import lkc_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_key,
  input  logic [63:0] in_value,
  input  logic [31:0] in_ttl,
  input  logic [47:0] in_now,
  output logic        out_strobe,
  output logic        out_found,
  output logic [63:0] out_read_value,
  output logic        out_evicted,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_miss_count,
  output logic [31:0] out_eviction_count,
  output logic [4:0]  out_entry_count
);

  logic [4:0] cap_r;
  logic       q_valid, q_pop;
  item_t      q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 5'd0;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  lkc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .in_key      (in_key),
    .in_value    (in_value),
    .in_ttl      (in_ttl),
    .in_now      (in_now),
    .busy        (busy),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  lkc_back #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cap                (cap_r),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .out_strobe         (out_strobe),
    .out_found          (out_found),
    .out_read_value     (out_read_value),
    .out_evicted        (out_evicted),
    .out_hit_count      (out_hit_count),
    .out_miss_count     (out_miss_count),
    .out_eviction_count (out_eviction_count),
    .out_entry_count    (out_entry_count)
  );

endmodule
